@@ design/mai_pkg.sv @@
// Package for the memory access index generator.
// Holds constants, state and control types, and the PRNG and region helpers.
// No dependencies.
package mai_pkg;

   localparam int unsigned ELEMENTS   = 8388608;
   localparam int unsigned IDX_W      = 23;
   localparam int unsigned ADDR_W     = 30;
   localparam logic [63:0] GOLDEN     = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] ZERO_SEED  = 64'd12345;
   localparam logic [63:0] RNG_RESET  = ZERO_SEED ^ GOLDEN;
   localparam logic [16:0] SHARE_DIV  = 17'(ELEMENTS / 100);
   localparam logic [3:0]  SHARE_MOD  = 4'(ELEMENTS % 100);
   localparam logic [24:0] RECIP_100  = 25'd21474837;

   localparam logic [3:0] MODE_SEQ      = 4'd0;
   localparam logic [3:0] MODE_RANDOM   = 4'd1;
   localparam logic [3:0] MODE_HOT      = 4'd2;
   localparam logic [3:0] MODE_MODERATE = 4'd3;
   localparam logic [3:0] MODE_COLD     = 4'd4;
   localparam logic [3:0] MODE_MIXED    = 4'd5;
   localparam logic [3:0] MODE_LOCAL    = 4'd6;
   localparam logic [3:0] MODE_REMOTE   = 4'd7;
   localparam logic [3:0] MODE_CHANGING = 4'd8;

   localparam logic [2:0] REG_MODE      = 3'd0;
   localparam logic [2:0] REG_SEED      = 3'd1;
   localparam logic [2:0] REG_HOT       = 3'd2;
   localparam logic [2:0] REG_MODERATE  = 3'd3;
   localparam logic [2:0] REG_PHASES    = 3'd4;
   localparam logic [2:0] REG_LIMIT     = 3'd5;
   localparam logic [2:0] REG_WORKER    = 3'd6;
   localparam logic [2:0] REG_WORKERS   = 3'd7;

   typedef enum logic [4:0] {
      ST_IDLE, ST_PREP, ST_TB, ST_TB_W, ST_TE, ST_TE_W, ST_WALK, ST_WALK_W,
      ST_PICK, ST_PICK_W, ST_PICK_Q, ST_PICK_R, ST_PER, ST_PER_W, ST_PHASE,
      ST_PHASE_W, ST_DRAW, ST_DRAW_W
   } state_type;

   typedef struct packed {
      logic start;
      logic long_op;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_rsp_type;

   function automatic logic [63:0] rng_step(input logic [63:0] s);
      logic [63:0] v;
      v = (s == 64'd0) ? ZERO_SEED : s;
      v = v ^ (v << 13);
      v = v ^ (v >> 7);
      v = v ^ (v << 17);
      return v;
   endfunction

   function automatic logic [63:0] reseed(input logic [63:0] seed, input logic [5:0] wn);
      logic [63:0] w;
      logic [63:0] prod;
      w    = {58'd0, wn} + 64'd1;
      prod = GOLDEN * w;
      return seed ^ prod;
   endfunction

   function automatic logic [23:0] share_of(input logic [6:0] pct);
      logic [6:0]  p;
      logic [23:0] big;
      logic [31:0] scaled;
      logic [23:0] frac;
      p      = (pct > 7'd100) ? 7'd100 : pct;
      big    = 24'(SHARE_DIV * p);
      scaled = {28'd0, SHARE_MOD} * {25'd0, p} * 32'd5243;
      frac   = 24'(scaled >> 19);
      return big + frac;
   endfunction

   function automatic logic [23:0] phase_span(input logic [4:0] pc);
      logic [23:0] r;
      case (pc)
         5'd2:    r = 24'd4194304;
         5'd3:    r = 24'd2796202;
         5'd4:    r = 24'd2097152;
         5'd5:    r = 24'd1677721;
         5'd6:    r = 24'd1398101;
         5'd7:    r = 24'd1198372;
         5'd8:    r = 24'd1048576;
         5'd9:    r = 24'd932067;
         5'd10:   r = 24'd838860;
         5'd11:   r = 24'd762600;
         5'd12:   r = 24'd699050;
         5'd13:   r = 24'd645277;
         5'd14:   r = 24'd599186;
         5'd15:   r = 24'd559240;
         default: r = 24'd524288;
      endcase
      return r;
   endfunction

endpackage

@@ design/mai_req_if.sv @@
// Request channel interface of the memory access index generator.
// Carries valid, ready and the restart flag; depends on nothing.
interface mai_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

@@ design/mai_rsp_if.sv @@
// Response channel interface of the memory access index generator.
// Carries valid, ready and one index word; depends on nothing.
interface mai_rsp_if;
   logic        valid;
   logic        ready;
   logic [22:0] element_index;
   logic [3:0]  phase;
   logic        last;
   modport source (output valid, output element_index, output phase, output last,
                   input ready);
   modport sink (input valid, input element_index, input phase, input last,
                 output ready);
endinterface

@@ design/mai_div.sv @@
// Serial restoring divider, one quotient bit per cycle, 32 or 64 dividend bits.
// Depends on mai_pkg.
module mai_div import mai_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type ctl,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output div_rsp_type stat,
   output logic [63:0] quotient,
   output logic [31:0] remainder
);
   logic [63:0] dvd_ff, dvd_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic        ge;

   always_comb begin
      trial   = {rem_ff, dvd_ff[63]};
      ge      = trial >= {1'b0, dsr_ff};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         rem_in = ge ? 32'(trial - {1'b0, dsr_ff}) : trial[31:0];
         dvd_in = {dvd_ff[62:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (ctl.start) begin
         dvd_in  = ctl.long_op ? dividend : {dividend[31:0], 32'd0};
         rem_in  = 32'd0;
         dsr_in  = divisor;
         cnt_in  = ctl.long_op ? 6'd63 : 6'd31;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;
endmodule

@@ design/memory_access_index_generator.sv @@
// Top level of the memory access index generator: config registers and sequencer.
// Depends on mai_pkg, mai_req_if, mai_rsp_if and mai_div.
//
// Usage: each word taken on req_chan (valid and ready high at a clock edge) asks
// for one element index; its restart bit reseeds the xorshift64 state and zeroes
// the operation count first. One word per request leaves on rsp_chan with the
// index, the phase and the last flag.
// The block takes one request at a time and is not ready while it works. Slice
// bounds, walk offsets, phase length, phase and draw spans run on one serial
// divider, with a 32-bit dividend or, for draws, a 64-bit one. The percent
// pick steps the random word, folds it, takes its quotient by 100 and then its
// remainder; a draw from a range of width 0 or 1 skips the divider.
// The result register frees the sequencer: a new request is taken while a
// result waits; a stalled receiver holds the block only when the next result
// is done. Reset is synchronous, loads the register defaults and the seeded
// generator state; there is no clearing pass. Write csr_ registers only while
// idle.
module memory_access_index_generator import mai_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mai_req_if.sink     req_chan,
   mai_rsp_if.source   rsp_chan,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data
);
   logic [3:0]  mode_ff;
   logic [63:0] seed_ff;
   logic [6:0]  hot_ff, moderate_ff;
   logic [4:0]  phases_ff;
   logic [31:0] limit_ff;
   logic [5:0]  worker_ff;
   logic [6:0]  workers_ff;

   state_type   state_ff, state_in;
   logic [63:0] rng_ff, rng_in;
   logic [31:0] op_ff, op_in;
   logic [ADDR_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [23:0] hot_end_ff, hot_end_in, mod_end_ff, mod_end_in;
   logic [31:0] per_ff, per_in;
   logic [3:0]  ph_ff, ph_in;
   logic [23:0] fold_ff, fold_in;
   logic [16:0] pq_ff, pq_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [22:0] rsp_idx_ff, rsp_idx_in;
   logic [3:0]  rsp_ph_ff, rsp_ph_in;
   logic        rsp_last_ff, rsp_last_in;

   div_req_type div_ctl;
   div_rsp_type div_stat;
   logic [63:0] div_dividend, div_quot;
   logic [31:0] div_divisor, div_rem;

   logic [6:0]  wc;
   logic [4:0]  pc;
   logic [23:0] psize;
   logic [24:0] mod_sum;
   logic [ADDR_W-1:0] span;
   logic [63:0] rng_next;
   logic [ADDR_W-1:0] te_q, ph_base;
   logic [48:0] recip_prod;
   logic [23:0] pct;
   logic        take;

   mai_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .stat      (div_stat),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_SEQ;
         seed_ff     <= ZERO_SEED;
         hot_ff      <= 7'd10;
         moderate_ff <= 7'd30;
         phases_ff   <= 5'd3;
         limit_ff    <= 32'd1000000;
         worker_ff   <= 6'd0;
         workers_ff  <= 7'd1;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_MODE:     mode_ff     <= csr_write_data[3:0];
            REG_SEED:     seed_ff     <= csr_write_data;
            REG_HOT:      hot_ff      <= csr_write_data[6:0];
            REG_MODERATE: moderate_ff <= csr_write_data[6:0];
            REG_PHASES:   phases_ff   <= csr_write_data[4:0];
            REG_LIMIT:    limit_ff    <= csr_write_data[31:0];
            REG_WORKER:   worker_ff   <= csr_write_data[5:0];
            REG_WORKERS:  workers_ff  <= csr_write_data[6:0];
            default:      ;
         endcase
      end
   end

   assign wc         = (workers_ff == 7'd0) ? 7'd1 : workers_ff;
   assign pc         = (phases_ff < 5'd2) ? 5'd2 : ((phases_ff > 5'd16) ? 5'd16 : phases_ff);
   assign psize      = phase_span(pc);
   assign span       = hi_ff - lo_ff;
   assign rng_next   = rng_step(rng_ff);
   assign recip_prod = {25'd0, fold_ff} * {24'd0, RECIP_100};
   assign pct        = fold_ff - {7'd0, pq_ff} * 24'd100;
   assign take       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      rng_in       = rng_ff;
      op_in        = op_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      hot_end_in   = hot_end_ff;
      mod_end_in   = mod_end_ff;
      per_in       = per_ff;
      ph_in        = ph_ff;
      fold_in      = fold_ff;
      pq_in        = pq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_ph_in    = rsp_ph_ff;
      rsp_last_in  = rsp_last_ff;
      div_ctl      = '0;
      div_dividend = 64'd0;
      div_divisor  = 32'd1;
      mod_sum      = 25'd0;
      te_q         = div_quot[ADDR_W-1:0];
      ph_base      = ADDR_W'(ph_ff * psize);

      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               ph_in  = 4'd0;
               idx_in = '0;
               if (req_chan.restart) begin
                  rng_in = reseed(seed_ff, worker_ff);
                  op_in  = 32'd0;
               end
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            hot_end_in = share_of(hot_ff);
            mod_sum    = {1'b0, hot_end_in} + {1'b0, share_of(moderate_ff)};
            mod_end_in = (mod_sum > 25'(ELEMENTS)) ? 24'(ELEMENTS) : mod_sum[23:0];
            case (mode_ff)
               MODE_SEQ, MODE_LOCAL, MODE_REMOTE, MODE_RANDOM: state_in = ST_TB;
               MODE_HOT, MODE_MODERATE, MODE_COLD, MODE_MIXED: state_in = ST_PICK;
               MODE_CHANGING:                                  state_in = ST_PER;
               default:                                        state_in = ST_DRAW_W;
            endcase
         end
         ST_TB, ST_TE: begin
            div_ctl.start = 1'b1;
            div_dividend  = (state_ff == ST_TB) ? {35'd0, worker_ff, 23'd0}
                                                : 64'({7'd0, worker_ff} + 7'd1) << 23;
            div_divisor   = {25'd0, wc};
            state_in      = (state_ff == ST_TB) ? ST_TB_W : ST_TE_W;
         end
         ST_TB_W: begin
            if (div_stat.done) begin
               lo_in    = div_quot[ADDR_W-1:0];
               state_in = ST_TE;
            end
         end
         ST_TE_W: begin
            if (div_stat.done) begin
               hi_in    = (te_q <= lo_ff) ? lo_ff + 1'b1 : te_q;
               state_in = (mode_ff == MODE_RANDOM) ? ST_DRAW : ST_WALK;
            end
         end
         ST_WALK: begin
            div_ctl.start = 1'b1;
            div_dividend  = {32'd0, op_ff};
            div_divisor   = 32'(span);
            state_in      = ST_WALK_W;
         end
         ST_WALK_W: begin
            if (div_stat.done) begin
               idx_in   = lo_ff + div_rem[ADDR_W-1:0];
               state_in = ST_DRAW_W;
            end
         end
         ST_PICK: begin
            rng_in   = rng_next;
            state_in = ST_PICK_W;
         end
         ST_PICK_W: begin
            fold_in  = {8'd0, rng_ff[15:0]} + {8'd0, rng_ff[31:16]} * 24'd36
                     + {8'd0, rng_ff[47:32]} * 24'd96 + {8'd0, rng_ff[63:48]} * 24'd56;
            state_in = ST_PICK_Q;
         end
         ST_PICK_Q: begin
            pq_in    = 17'(recip_prod >> 31);
            state_in = ST_PICK_R;
         end
         ST_PICK_R: begin
            lo_in    = '0;
            hi_in    = ADDR_W'(ELEMENTS);
            state_in = ST_DRAW;
            case (mode_ff)
               MODE_HOT: begin
                  if (pct < 24'd99) hi_in = ADDR_W'(hot_end_ff);
               end
               MODE_MODERATE: begin
                  if (pct < 24'd70) begin
                     lo_in = ADDR_W'(hot_end_ff);
                     hi_in = ADDR_W'(mod_end_ff);
                  end
               end
               MODE_COLD: begin
                  if (pct < 24'd10) hi_in = ADDR_W'(hot_end_ff);
               end
               default: begin
                  if (pct < 24'd70) begin
                     hi_in = ADDR_W'(hot_end_ff);
                  end else if (pct < 24'd95) begin
                     lo_in = ADDR_W'(hot_end_ff);
                     hi_in = ADDR_W'(mod_end_ff);
                  end else begin
                     lo_in = ADDR_W'(mod_end_ff);
                  end
               end
            endcase
         end
         ST_PER: begin
            div_ctl.start = 1'b1;
            div_dividend  = {32'd0, limit_ff};
            div_divisor   = {27'd0, pc};
            state_in      = ST_PER_W;
         end
         ST_PER_W: begin
            if (div_stat.done) begin
               per_in   = (div_quot[31:0] == 32'd0) ? 32'd1 : div_quot[31:0];
               state_in = ST_PHASE;
            end
         end
         ST_PHASE: begin
            div_ctl.start = 1'b1;
            div_dividend  = {32'd0, op_ff};
            div_divisor   = per_ff;
            state_in      = ST_PHASE_W;
         end
         ST_PHASE_W: begin
            if (div_stat.done) begin
               ph_in    = (div_quot[31:0] >= {27'd0, pc}) ? 4'(pc - 5'd1) : div_quot[3:0];
               state_in = ST_PHASE_W;
               if (div_stat.done) state_in = ST_DRAW;
            end
         end
         ST_DRAW: begin
            if (mode_ff == MODE_CHANGING && lo_ff == '0 && hi_ff == '0) begin
               lo_in    = ph_base;
               hi_in    = ({1'b0, ph_ff} + 5'd1 == pc) ? ADDR_W'(ELEMENTS)
                                                      : ph_base + ADDR_W'(psize);
            end else if (hi_ff <= lo_ff + 1'b1) begin
               idx_in   = lo_ff;
               state_in = ST_DRAW_W;
               lo_in    = '0;
               hi_in    = '0;
            end else begin
               rng_in          = rng_next;
               div_ctl.start   = 1'b1;
               div_ctl.long_op = 1'b1;
               div_dividend    = rng_next;
               div_divisor     = 32'(span);
               state_in        = ST_DRAW_W;
               lo_in           = '0;
               hi_in           = '0;
               idx_in          = lo_ff;
            end
         end
         ST_DRAW_W: begin
            if (!div_stat.busy && !div_ctl.start && (!rsp_valid_ff || rsp_chan.ready)) begin
               if (div_stat.done) idx_in = idx_ff + div_rem[ADDR_W-1:0];
               rsp_valid_in = 1'b1;
               rsp_idx_in   = (idx_in >= ADDR_W'(ELEMENTS)) ? 23'(ELEMENTS - 1)
                                                            : idx_in[22:0];
               rsp_ph_in    = ph_ff;
               rsp_last_in  = (limit_ff != 32'd0) && (op_ff == limit_ff - 32'd1);
               op_in        = op_ff + 32'd1;
               lo_in        = '0;
               hi_in        = '0;
               state_in     = ST_IDLE;
            end else if (div_stat.done) begin
               idx_in = idx_ff + div_rem[ADDR_W-1:0];
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rng_ff       <= RNG_RESET;
         op_ff        <= 32'd0;
         rsp_valid_ff <= 1'b0;
         lo_ff        <= '0;
         hi_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rng_ff       <= rng_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
      end
      idx_ff      <= idx_in;
      hot_end_ff  <= hot_end_in;
      mod_end_ff  <= mod_end_in;
      per_ff      <= per_in;
      ph_ff       <= ph_in;
      fold_ff     <= fold_in;
      pq_ff       <= pq_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_ph_ff   <= rsp_ph_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.element_index = rsp_idx_ff;
   assign rsp_chan.phase         = rsp_ph_ff;
   assign rsp_chan.last          = rsp_last_ff;
endmodule

@@ tb/sv/mai_index_checker.sv @@
// Checker for the memory access index generator: watches both channels,
// predicts every index word from its own model of the generator and compares.
// Depends on mai_pkg, mai_req_if and mai_rsp_if.
`timescale 1ns / 100ps
module mai_index_checker import mai_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mai_req_if          req_mon,
   mai_rsp_if          rsp_mon,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data,
   output int          error_count,
   output int          pending_count,
   output int          word_count
);
   typedef struct packed {
      logic [22:0] element_index;
      logic [3:0]  phase;
      logic        last;
   } index_word_type;

   localparam logic [63:0] NUM_ELEMENTS = 64'd8388608;

   logic [3:0]  pattern_mode;
   logic [63:0] seed_value;
   logic [6:0]  hot_share;
   logic [6:0]  moderate_share;
   logic [4:0]  phase_count;
   logic [31:0] iteration_limit;
   logic [5:0]  worker_number;
   logic [6:0]  worker_count;
   logic [63:0] gen_state;
   logic [31:0] op_count;
   index_word_type expected_words[$];

   function automatic logic [63:0] next_rnd();
      logic [63:0] v;
      v = (gen_state == 64'd0) ? 64'd12345 : gen_state;
      v = v ^ (v << 13);
      v = v ^ (v >> 7);
      v = v ^ (v << 17);
      gen_state = v;
      return v;
   endfunction

   function automatic logic [63:0] pick(input logic [63:0] lo, input logic [63:0] hi);
      if (hi <= lo + 64'd1) return lo;
      return lo + next_rnd() % (hi - lo);
   endfunction

   function automatic logic [63:0] region_size(input logic [6:0] pct);
      logic [63:0] p;
      p = (pct > 7'd100) ? 64'd100 : {57'd0, pct};
      return (NUM_ELEMENTS / 100) * p + (NUM_ELEMENTS % 100) * p / 100;
   endfunction

   function automatic index_word_type predict_index(input logic restart);
      logic [63:0] wc, pc, op, tb, te, hot_end, mod_end, idx, ph, r, psize, per, b, e;
      index_word_type w;
      wc = (worker_count == 0) ? 64'd1 : {57'd0, worker_count};
      pc = (phase_count < 2) ? 64'd2 : ((phase_count > 16) ? 64'd16 : {59'd0, phase_count});
      idx = 0;
      ph = 0;
      if (restart) begin
         gen_state = seed_value ^ (64'h9e3779b97f4a7c15 * ({58'd0, worker_number} + 64'd1));
         op_count = 0;
      end
      op = {32'd0, op_count};
      tb = {58'd0, worker_number} * NUM_ELEMENTS / wc;
      te = ({58'd0, worker_number} + 64'd1) * NUM_ELEMENTS / wc;
      if (te <= tb) te = tb + 1;
      hot_end = region_size(hot_share);
      mod_end = hot_end + region_size(moderate_share);
      if (mod_end > NUM_ELEMENTS) mod_end = NUM_ELEMENTS;
      case (pattern_mode)
         MODE_SEQ, MODE_LOCAL, MODE_REMOTE: idx = tb + op % (te - tb);
         MODE_RANDOM: idx = pick(tb, te);
         MODE_HOT: idx = (next_rnd() % 100 < 99) ? pick(0, hot_end) : pick(0, NUM_ELEMENTS);
         MODE_MODERATE:
            idx = (next_rnd() % 100 < 70) ? pick(hot_end, mod_end) : pick(0, NUM_ELEMENTS);
         MODE_COLD: idx = (next_rnd() % 100 < 10) ? pick(0, hot_end) : pick(0, NUM_ELEMENTS);
         MODE_MIXED: begin
            r = next_rnd() % 100;
            if (r < 70) idx = pick(0, hot_end);
            else if (r < 95) idx = pick(hot_end, mod_end);
            else idx = pick(mod_end, NUM_ELEMENTS);
         end
         MODE_CHANGING: begin
            psize = NUM_ELEMENTS / pc;
            per = {32'd0, iteration_limit} / pc;
            if (per == 0) per = 1;
            ph = op / per;
            if (ph >= pc) ph = pc - 1;
            b = ph * psize;
            e = (ph + 1 == pc) ? NUM_ELEMENTS : b + psize;
            idx = pick(b, e);
         end
         default: idx = 0;
      endcase
      if (idx >= NUM_ELEMENTS) idx = NUM_ELEMENTS - 1;
      w.element_index = idx[22:0];
      w.phase = ph[3:0];
      w.last = (iteration_limit != 0 && op == {32'd0, iteration_limit} - 64'd1);
      op_count = op_count + 32'd1;
      return w;
   endfunction

   assign pending_count = expected_words.size();

   always @(posedge clock) begin
      index_word_type got, want;
      if (reset) begin
         pattern_mode <= MODE_SEQ;
         seed_value <= 64'd12345;
         hot_share <= 7'd10;
         moderate_share <= 7'd30;
         phase_count <= 5'd3;
         iteration_limit <= 32'd1000000;
         worker_number <= 6'd0;
         worker_count <= 7'd1;
         gen_state = 64'd12345 ^ 64'h9e3779b97f4a7c15;
         op_count = 0;
         error_count <= 0;
         word_count <= 0;
         expected_words.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_MODE:     pattern_mode <= csr_write_data[3:0];
               REG_SEED:     seed_value <= csr_write_data;
               REG_HOT:      hot_share <= csr_write_data[6:0];
               REG_MODERATE: moderate_share <= csr_write_data[6:0];
               REG_PHASES:   phase_count <= csr_write_data[4:0];
               REG_LIMIT:    iteration_limit <= csr_write_data[31:0];
               REG_WORKER:   worker_number <= csr_write_data[5:0];
               default:      worker_count <= csr_write_data[6:0];
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            expected_words.push_back(predict_index(req_mon.restart));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.element_index, rsp_mon.phase, rsp_mon.last};
            word_count <= word_count + 1;
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word idx=%0d phase=%0d last=%0b", $time,
                        got.element_index, got.phase, got.last);
               error_count <= error_count + 1;
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected idx=%0d phase=%0d last=%0b, got idx=%0d phase=%0d last=%0b",
                           $time, want.element_index, want.phase, want.last,
                           got.element_index, got.phase, got.last);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

@@ tb/sv/tb_memory_access_index_generator.sv @@
// Top of the memory access index generator testbench: clock, reset, config
// phases and request stimulus with random stalls. Depends on mai_pkg, the
// channel interfaces, the block and mai_index_checker.
`timescale 1ns / 100ps
module tb_memory_access_index_generator import mai_pkg::*;;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = REG_MODE;
   logic [63:0] csr_write_data = 64'd0;
   int          error_count, pending_count, word_count;
   int          cycle_count = 0;
   int          sent_count = 0;
   int          sent_target = 1900;
   int          stall_mode = 0;
   bit          long_stall = 1'b0;

   mai_req_if req_chan();
   mai_rsp_if rsp_chan();

   memory_access_index_generator DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   mai_index_checker u_checker (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .error_count(error_count),
      .pending_count(pending_count), .word_count(word_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 10000000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_memory_access_index_generator: done, errors");
         $finish;
      end
   end

   // receiver: short random stalls, a few long ones, and a forced long hold
   always @(posedge clock) begin
      int gap;
      if (reset) rsp_chan.ready <= 1'b0;
      else if (long_stall) begin
         rsp_chan.ready <= 1'b0;
         repeat (600) @(posedge clock);
         long_stall = 1'b0;
      end else if (stall_mode == 0) rsp_chan.ready <= 1'b1;
      else begin
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
         if ($urandom_range(0, 1) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic drain_words();
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic send_request(input logic restart, input bit idle_gaps);
      int gap;
      if (idle_gaps && $urandom_range(0, 2) == 0) begin
         gap = ($urandom_range(0, 24) == 0) ? $urandom_range(30, 300) : $urandom_range(1, 4);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.restart <= restart;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic run_phase(input logic [3:0] mode, input logic [63:0] seed,
                            input logic [6:0] hot, input logic [6:0] moder,
                            input logic [4:0] phases, input logic [31:0] limit,
                            input logic [5:0] worker, input logic [6:0] workers,
                            input int count);
      req_chan.valid <= 1'b0;
      drain_words();
      write_reg(REG_MODE, {60'd0, mode});
      write_reg(REG_SEED, seed);
      write_reg(REG_HOT, {57'd0, hot});
      write_reg(REG_MODERATE, {57'd0, moder});
      write_reg(REG_PHASES, {59'd0, phases});
      write_reg(REG_LIMIT, {32'd0, limit});
      write_reg(REG_WORKER, {58'd0, worker});
      write_reg(REG_WORKERS, {57'd0, workers});
      send_request(1'b1, 1'b0);
      for (int i = 1; i < count; i++)
         send_request($urandom_range(0, 15) == 0, 1'b1);
      req_chan.valid <= 1'b0;
   endtask

   initial begin
      logic [31:0] limit;
      logic [6:0]  workers;
      req_chan.valid = 1'b0;
      req_chan.restart = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: reset defaults, then extremes of every register
      send_request(1'b0, 1'b0);
      send_request(1'b0, 1'b0);
      send_request(1'b1, 1'b0);
      req_chan.valid <= 1'b0;
      run_phase(MODE_SEQ, 64'd0, 7'd0, 7'd127, 5'd0, 32'd3, 6'd63, 7'd0, 5);
      run_phase(MODE_RANDOM, 64'hFFFF_FFFF_FFFF_FFFF, 7'd100, 7'd100, 5'd31, 32'd1, 6'd63, 7'd64, 3);
      run_phase(MODE_CHANGING, 64'd0, 7'd127, 7'd1, 5'd1, 32'd0, 6'd0, 7'd127, 4);
      run_phase(MODE_CHANGING, 64'h9e3779b97f4a7c15, 7'd1, 7'd127, 5'd16, 32'hFFFF_FFFF, 6'd5, 7'd3, 3);
      run_phase(MODE_MIXED, 64'h9e3779b97f4a7c15, 7'd100, 7'd100, 5'd2, 32'd2, 6'd0, 7'd1, 4);
      run_phase(4'd15, 64'd1, 7'd0, 7'd0, 5'd17, 32'd2, 6'd1, 7'd1, 3);
      run_phase(MODE_HOT, 64'd7, 7'd0, 7'd0, 5'd2, 32'd5, 6'd2, 7'd2, 3);
      stall_mode = 1;
      // long receiver hold while requests keep coming
      long_stall = 1'b1;
      run_phase(MODE_SEQ, 64'd99, 7'd10, 7'd30, 5'd3, 32'd50, 6'd0, 7'd1, 12);
      while (sent_count < sent_target) begin
         limit = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 80);
         workers = $urandom_range(0, 3) == 0 ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 64));
         run_phase(4'($urandom_range(0, 9) == 0 ? $urandom_range(9, 15) : $urandom_range(0, 8)),
                   {$urandom, $urandom}, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                   5'($urandom_range(0, 31)), limit, 6'($urandom_range(0, 63)), workers,
                   $urandom_range(10, 60));
      end
      drain_words();
      $display("ran %0d requests, %0d index words checked over all modes and register extremes",
               sent_count, word_count);
      if (error_count == 0)
         $display("tb_memory_access_index_generator: done, clean");
      else
         $display("tb_memory_access_index_generator: done, errors");
      $finish;
   end
endmodule
